@@ rtl/core/ebg_pkg.sv @@
// Package for the exponential backoff generator: register codes, reset values,
// the configuration bundle type and widths shared by all modules.
// No dependencies.
package ebg_pkg;

   localparam int FRACTION_BITS_DEF = 16;

   localparam int BOUND_W  = 32;
   localparam int FACTOR_W = 16;
   localparam int ZCOUNT_W = 8;
   localparam int GROWTH_W = BOUND_W + FACTOR_W;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_INDEX_W = 2;

   localparam logic [ZCOUNT_W-1:0] ZERO_COUNT_RST    = 8'd1;
   localparam logic [FACTOR_W-1:0] GROWTH_FACTOR_RST = 16'd4;
   localparam logic [BOUND_W-1:0]  FIRST_BOUND_RST   = 32'd16;
   localparam logic [BOUND_W-1:0]  MAX_BOUND_RST     = 32'd1048576;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_ZERO_COUNT    = 2'd0,
      REG_GROWTH_FACTOR = 2'd1,
      REG_FIRST_BOUND   = 2'd2,
      REG_MAX_BOUND     = 2'd3
   } ebg_reg_type;

   typedef struct packed {
      logic [ZCOUNT_W-1:0] zero_count;
      logic [FACTOR_W-1:0] growth_factor;
      logic [BOUND_W-1:0]  first_bound;
      logic [BOUND_W-1:0]  max_bound;
      logic                bad;
      logic                reload;
   } ebg_cfg_type;

endpackage

@@ rtl/core/ebg_cfg.sv @@
// Configuration registers of the backoff generator, the invalid-setting flag
// and the reload pulse that follows every write. Uses ebg_pkg.
module ebg_cfg import ebg_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output ebg_cfg_type            cfg
);

   logic [ZCOUNT_W-1:0] zero_count_ff;
   logic [FACTOR_W-1:0] growth_factor_ff;
   logic [BOUND_W-1:0]  first_bound_ff;
   logic [BOUND_W-1:0]  max_bound_ff;
   logic                reload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_count_ff    <= ZERO_COUNT_RST;
         growth_factor_ff <= GROWTH_FACTOR_RST;
         first_bound_ff   <= FIRST_BOUND_RST;
         max_bound_ff     <= MAX_BOUND_RST;
         reload_ff        <= 1'b0;
      end else begin
         reload_ff <= csr_we;
         if (csr_we) begin
            unique case (ebg_reg_type'(csr_index))
               REG_ZERO_COUNT:    zero_count_ff    <= csr_wdata[ZCOUNT_W-1:0];
               REG_GROWTH_FACTOR: growth_factor_ff <= csr_wdata[FACTOR_W-1:0];
               REG_FIRST_BOUND:   first_bound_ff   <= csr_wdata[BOUND_W-1:0];
               REG_MAX_BOUND:     max_bound_ff     <= csr_wdata[BOUND_W-1:0];
               default:           zero_count_ff    <= zero_count_ff;
            endcase
         end
      end
   end

   always_comb begin
      cfg.zero_count    = zero_count_ff;
      cfg.growth_factor = growth_factor_ff;
      cfg.first_bound   = first_bound_ff;
      cfg.max_bound     = max_bound_ff;
      cfg.bad           = (growth_factor_ff == '0) || (first_bound_ff == '0) ||
                          (max_bound_ff == '0) || (first_bound_ff > max_bound_ff);
      // state reloads in the cycle after the write, from the updated registers
      cfg.reload        = reload_ff;
   end

endmodule

@@ rtl/core/ebg_step.sv @@
// Backoff state (zeros left, current bound) and the per-word arithmetic:
// scaled backoff and the multiply-saturate bound update. Uses ebg_pkg.
module ebg_step import ebg_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ebg_cfg_type              cfg,
   input  logic                     step_en,
   input  logic                     restart,
   input  logic [FRACTION_BITS:0]   random_fraction,
   output logic [BOUND_W-1:0]       backoff,
   output logic                     config_error
);

   localparam int SCALE_W = BOUND_W + FRACTION_BITS + 1;

   logic [ZCOUNT_W-1:0]      zeros_left_ff, zeros_left_in;
   logic [BOUND_W-1:0]       bound_ff, bound_in;
   logic [FRACTION_BITS:0]   frac_sat;
   logic [SCALE_W-1:0]       scaled;
   logic [GROWTH_W-1:0]      grown;
   logic [BOUND_W-1:0]       grown_sat;
   logic                     zero_out;

   // clamp anything above full scale to the full bound
   assign frac_sat = random_fraction[FRACTION_BITS] ?
                     {1'b1, {FRACTION_BITS{1'b0}}} : random_fraction;
   assign scaled   = SCALE_W'(bound_ff) * SCALE_W'(frac_sat);

   assign grown     = GROWTH_W'(bound_ff) * GROWTH_W'(cfg.growth_factor);
   assign grown_sat = (grown > GROWTH_W'(cfg.max_bound)) ? cfg.max_bound
                                                         : grown[BOUND_W-1:0];

   assign zero_out     = restart || cfg.bad || (zeros_left_ff != '0);
   assign backoff      = zero_out ? '0 : scaled[FRACTION_BITS +: BOUND_W];
   assign config_error = cfg.bad;

   always_comb begin
      zeros_left_in = zeros_left_ff;
      bound_in      = bound_ff;
      priority if (cfg.reload || (step_en && restart)) begin
         zeros_left_in = cfg.zero_count;
         bound_in      = cfg.first_bound;
      end else if (!step_en || cfg.bad) begin
         zeros_left_in = zeros_left_ff;
      end else if (zeros_left_ff != '0) begin
         zeros_left_in = zeros_left_ff - 1'b1;
      end else if (bound_ff < cfg.max_bound) begin
         bound_in = grown_sat;
      end else begin
         // at or above the ceiling: hold the bound
         bound_in = bound_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zeros_left_ff <= ZERO_COUNT_RST;
         bound_ff      <= FIRST_BOUND_RST;
      end else begin
         zeros_left_ff <= zeros_left_in;
         bound_ff      <= bound_in;
      end
   end

   a_bound_within_max: assert property (@(posedge clock) disable iff (reset)
      (!cfg.bad && !cfg.reload) |-> (bound_ff <= cfg.max_bound))
      else $error("current bound above max_bound with valid configuration");

   a_backoff_within_bound: assert property (@(posedge clock) disable iff (reset)
      step_en |-> (backoff <= bound_ff))
      else $error("backoff exceeds current bound");

endmodule

@@ rtl/core/exponential_backoff_generator.sv @@
// Top level of the exponential backoff generator: input register, result
// register and handshakes around ebg_cfg and ebg_step. Uses ebg_pkg.
//
//   channel   direction  handshake              payload
//   req       in         req_valid/req_ready    req_restart, req_random_fraction
//   rsp       out        rsp_valid/rsp_ready    rsp_backoff, rsp_config_error
//   csr       in         csr_we                 csr_index, csr_wdata
//
// Sustains one word per cycle while rsp_ready is high; rsp_valid is registered.
// The bound update (one 32x16 multiply and saturate) is combinational logic.
// Reset is synchronous: config and state take ebg_pkg defaults, valid flags clear.
// A stalled rsp holds its word while the input register still takes one more word.
// A csr write reloads the state on the following cycle.
module exponential_backoff_generator import ebg_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_restart,
   input  logic [FRACTION_BITS:0]   req_random_fraction,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [BOUND_W-1:0]       rsp_backoff,
   output logic                     rsp_config_error,
   input  logic                     csr_we,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata
);

   ebg_cfg_type              cfg;
   logic                     in_valid_ff;
   logic                     in_restart_ff;
   logic [FRACTION_BITS:0]   in_frac_ff;
   logic                     out_valid_ff;
   logic [BOUND_W-1:0]       out_backoff_ff;
   logic                     out_error_ff;
   logic                     advance;
   logic [BOUND_W-1:0]       step_backoff;
   logic                     step_error;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   ebg_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ebg_step #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_step (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .step_en         (advance),
      .restart         (in_restart_ff),
      .random_fraction (in_frac_ff),
      .backoff         (step_backoff),
      .config_error    (step_error)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_restart_ff <= req_restart;
         in_frac_ff    <= req_random_fraction;
      end
      if (advance) begin
         out_backoff_ff <= step_backoff;
         out_error_ff   <= step_error;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_backoff      = out_backoff_ff;
   assign rsp_config_error = out_error_ff;

   a_error_forces_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_config_error) |-> (rsp_backoff == '0))
      else $error("nonzero backoff reported with configuration error");

   a_advance_fills_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("word moved out of input register was lost");

endmodule
